>>> src/gbdf_pkg.sv
// Package for the grid breadth-first distance field block.
// Holds command codes, fixed field widths, datapath operation codes and the
// controller/datapath interface structs. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gbdf_pkg;

	localparam int CMD_W      = 2;
	localparam int COORD_IN_W = 5;
	localparam int DIST_W     = 11;
	localparam int POWER_W    = 10;

	localparam int GRID_WIDTH_DEF  = 32;
	localparam int GRID_HEIGHT_DEF = 32;

	localparam logic [DIST_W-1:0] UNREACHED = '1;

	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EXPAND = 2'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

	typedef enum logic [3:0] {
		OP_IDLE  = 4'd0,
		OP_CLEAR = 4'd1,
		OP_LOAD  = 4'd2,
		OP_QUERY = 4'd3,
		OP_START = 4'd4,
		OP_POP   = 4'd5,
		OP_CUR   = 4'd6,
		OP_NB_RD = 4'd7,
		OP_NB_WR = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		RS_MEM  = 2'd0,
		RS_ZERO = 2'd1,
		RS_CUR  = 2'd2,
		RS_UNR  = 2'd3
	} res_src_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] nb_sel;
		logic       latch;
		logic       cap_cur;
		res_src_t   res_src;
		logic       res_load;
	} gbdf_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             in_ok;
		logic             q_empty;
		logic             clr_last;
		logic             res_free;
	} gbdf_stat_t;

endpackage

`default_nettype wire

>>> src/grid_bfs_distance_field.sv
// Top level of the grid breadth-first distance field.
// Joins the controller gbdf_ctrl and the datapath gbdf_dpath; depends on gbdf_pkg.
//
//   Channel  Handshake              Contents
//   cmd      cmd_valid/cmd_ready    command, cell_x, cell_y, passable
//   res      res_valid/res_ready    distance_out, in_range, queue_empty
//   cfg      cfg_we                 cfg_wdata (move_power)
//
// One word is worked on at a time. A start on a cell inside the grid first clears the
// distance memory by a sweep of one entry per cycle. After reset the same sweep runs
// with cmd_ready low. A stalled result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module grid_bfs_distance_field #(
	parameter int GRID_WIDTH  = gbdf_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = gbdf_pkg::GRID_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_ready,
	input  logic [gbdf_pkg::CMD_W-1:0]        command,
	input  logic [gbdf_pkg::COORD_IN_W-1:0]   cell_x,
	input  logic [gbdf_pkg::COORD_IN_W-1:0]   cell_y,
	input  logic                              passable,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [gbdf_pkg::DIST_W-1:0]       distance_out,
	output logic                              in_range,
	output logic                              queue_empty,
	input  logic                              cfg_we,
	input  logic [gbdf_pkg::POWER_W-1:0]      cfg_wdata
);
	import gbdf_pkg::*;

	gbdf_cmd_t  ctl;
	gbdf_stat_t stat;

	gbdf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	gbdf_dpath #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.command      (command),
		.cell_x       (cell_x),
		.cell_y       (cell_y),
		.passable     (passable),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.distance_out (distance_out),
		.in_range     (in_range),
		.queue_empty  (queue_empty)
	);

endmodule

`default_nettype wire

>>> src/gbdf_ctrl.sv
// Controller state machine for the grid breadth-first distance field.
// Sequences clearing sweeps, loads, starts, expansions and queries.
// Depends on gbdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbdf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  gbdf_pkg::gbdf_stat_t  stat,
	output gbdf_pkg::gbdf_cmd_t   ctl
);
	import gbdf_pkg::*;

	typedef enum logic [11:0] {
		S_RCLR  = 12'b000000000001,
		S_IDLE  = 12'b000000000010,
		S_DISP  = 12'b000000000100,
		S_LOAD  = 12'b000000001000,
		S_QUERY = 12'b000000010000,
		S_SCLR  = 12'b000000100000,
		S_INIT  = 12'b000001000000,
		S_POP   = 12'b000010000000,
		S_CUR   = 12'b000100000000,
		S_NBRD  = 12'b001000000000,
		S_NBWR  = 12'b010000000000,
		S_RES   = 12'b100000000000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] nb_q, nb_d;
	res_src_t   res_src_q, res_src_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_RCLR;
			nb_q      <= '0;
			res_src_q <= RS_UNR;
		end else begin
			state_q   <= state_d;
			nb_q      <= nb_d;
			res_src_q <= res_src_d;
		end
	end

	assign cmd_ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		nb_d         = nb_q;
		res_src_d    = res_src_q;
		ctl          = '0;
		ctl.op       = OP_IDLE;
		ctl.nb_sel   = nb_q;
		ctl.res_src  = res_src_q;
		case (state_q)
			S_RCLR: begin
				ctl.op = OP_CLEAR;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.latch = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.command)
					CMD_LOAD: begin
						res_src_d = RS_MEM;
						state_d   = S_LOAD;
					end
					CMD_START: begin
						res_src_d = RS_ZERO;
						state_d   = stat.in_ok ? S_SCLR : S_RES;
					end
					CMD_EXPAND: begin
						res_src_d = stat.q_empty ? RS_UNR : RS_CUR;
						state_d   = stat.q_empty ? S_RES : S_POP;
					end
					CMD_QUERY: begin
						res_src_d = RS_MEM;
						state_d   = S_QUERY;
					end
					default: begin
						res_src_d = RS_UNR;
						state_d   = S_RES;
					end
				endcase
			end
			S_LOAD: begin
				ctl.op  = OP_LOAD;
				state_d = S_RES;
			end
			S_QUERY: begin
				ctl.op  = OP_QUERY;
				state_d = S_RES;
			end
			S_SCLR: begin
				ctl.op = OP_CLEAR;
				if (stat.clr_last) begin
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				ctl.op  = OP_START;
				state_d = S_RES;
			end
			S_POP: begin
				ctl.op  = OP_POP;
				nb_d    = '0;
				state_d = S_CUR;
			end
			S_CUR: begin
				ctl.op  = OP_CUR;
				state_d = S_NBRD;
			end
			S_NBRD: begin
				ctl.op      = OP_NB_RD;
				ctl.cap_cur = (nb_q == 2'd0);
				state_d     = S_NBWR;
			end
			S_NBWR: begin
				ctl.op = OP_NB_WR;
				if (nb_q == 2'd3) begin
					state_d = S_RES;
				end else begin
					nb_d    = nb_q + 2'd1;
					state_d = S_NBRD;
				end
			end
			S_RES: begin
				if (stat.res_free) begin
					ctl.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> src/gbdf_dpath.sv
// Datapath for the grid breadth-first distance field: passability map,
// distance store and search queue memories, queue pointers, neighbor
// generation, configuration register and result register. Depends on gbdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbdf_dpath #(
	parameter int GRID_WIDTH  = gbdf_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = gbdf_pkg::GRID_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gbdf_pkg::gbdf_cmd_t               ctl,
	output gbdf_pkg::gbdf_stat_t              stat,
	input  logic [gbdf_pkg::CMD_W-1:0]        command,
	input  logic [gbdf_pkg::COORD_IN_W-1:0]   cell_x,
	input  logic [gbdf_pkg::COORD_IN_W-1:0]   cell_y,
	input  logic                              passable,
	input  logic                              cfg_we,
	input  logic [gbdf_pkg::POWER_W-1:0]      cfg_wdata,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [gbdf_pkg::DIST_W-1:0]       distance_out,
	output logic                              in_range,
	output logic                              queue_empty
);
	import gbdf_pkg::*;

	localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
	localparam int XW         = $clog2(GRID_WIDTH);
	localparam int YW         = $clog2(GRID_HEIGHT);
	localparam int QW         = XW + YW;
	localparam int IDX_W      = $clog2(CELL_COUNT);
	localparam int PTR_W      = IDX_W + 1;

	function automatic logic [IDX_W-1:0] cell_index(input logic [XW-1:0] x,
			input logic [YW-1:0] y);
		cell_index = IDX_W'(y) * IDX_W'(GRID_WIDTH) + IDX_W'(x);
	endfunction

	// Latched input word and configuration.
	logic [CMD_W-1:0]      command_q;
	logic [COORD_IN_W-1:0] cell_x_q, cell_y_q;
	logic                  passable_q;
	logic [POWER_W-1:0]    move_power_q;

	// Memories.
	logic                  pass_mem [CELL_COUNT];
	logic [DIST_W-1:0]     dist_mem [CELL_COUNT];
	logic [QW-1:0]         queue_mem [CELL_COUNT];

	logic                  pass_we, pass_re, pass_rd_q;
	logic [IDX_W-1:0]      pass_addr;
	logic                  dist_we, dist_re;
	logic [IDX_W-1:0]      dist_addr;
	logic [DIST_W-1:0]     dist_wd, dist_rd_q;
	logic                  q_we, q_re;
	logic [IDX_W-1:0]      q_addr;
	logic [QW-1:0]         q_wd, q_rd_q;

	// Queue pointers and sweep counter.
	logic [PTR_W-1:0]      head_q, tail_q;
	logic [IDX_W-1:0]      clr_cnt_q;
	logic                  clr_last, q_full;

	// Expansion registers.
	logic [XW-1:0]         cur_x_q;
	logic [YW-1:0]         cur_y_q;
	logic [DIST_W-1:0]     cur_d_q;
	logic [IDX_W-1:0]      nb_idx_q;
	logic                  nb_ok_q;
	logic [QW-1:0]         nb_cell_q;

	// Result register.
	logic                  res_valid_q, in_range_q, queue_empty_q;
	logic [DIST_W-1:0]     distance_q;

	logic                  in_ok;
	logic [IDX_W-1:0]      in_idx, cur_idx;
	logic [XW:0]           nx;
	logic [YW:0]           ny;
	logic                  nb_ok;
	logic [IDX_W-1:0]      nb_idx;
	logic [DIST_W:0]       nd;
	logic                  relax;
	logic [DIST_W-1:0]     res_d;

	assign in_ok  = (32'(cell_x_q) < 32'(GRID_WIDTH)) && (32'(cell_y_q) < 32'(GRID_HEIGHT));
	assign in_idx = in_ok ? cell_index(XW'(cell_x_q), YW'(cell_y_q)) : '0;
	assign cur_idx = cell_index(q_rd_q[XW-1:0], q_rd_q[QW-1:XW]);

	always_comb begin
		nx    = {1'b0, cur_x_q};
		ny    = {1'b0, cur_y_q};
		nb_ok = 1'b0;
		case (ctl.nb_sel)
			2'd0: begin
				nx    = {1'b0, cur_x_q} + (XW+1)'(1);
				nb_ok = nx < (XW+1)'(GRID_WIDTH);
			end
			2'd1: begin
				nx    = {1'b0, cur_x_q} - (XW+1)'(1);
				nb_ok = (cur_x_q != '0);
			end
			2'd2: begin
				ny    = {1'b0, cur_y_q} + (YW+1)'(1);
				nb_ok = ny < (YW+1)'(GRID_HEIGHT);
			end
			default: begin
				ny    = {1'b0, cur_y_q} - (YW+1)'(1);
				nb_ok = (cur_y_q != '0);
			end
		endcase
	end

	assign nb_idx = nb_ok ? cell_index(nx[XW-1:0], ny[YW-1:0]) : '0;

	assign nd    = {1'b0, cur_d_q} + (DIST_W+1)'(1);
	assign relax = nb_ok_q && pass_rd_q && (nd < {1'b0, UNREACHED}) &&
		(nd < {1'b0, dist_rd_q});

	assign clr_last = (clr_cnt_q == IDX_W'(CELL_COUNT - 1));
	assign q_full   = (tail_q == PTR_W'(CELL_COUNT));

	// Memory port selection.
	always_comb begin
		pass_we   = 1'b0;
		pass_re   = 1'b0;
		pass_addr = in_idx;
		dist_we   = 1'b0;
		dist_re   = 1'b0;
		dist_addr = in_idx;
		dist_wd   = UNREACHED;
		q_we      = 1'b0;
		q_re      = 1'b0;
		q_addr    = head_q[IDX_W-1:0];
		q_wd      = nb_cell_q;
		case (ctl.op)
			OP_CLEAR: begin
				dist_we   = 1'b1;
				dist_addr = clr_cnt_q;
			end
			OP_LOAD: begin
				pass_we = in_ok;
				dist_re = 1'b1;
			end
			OP_QUERY: begin
				dist_re = 1'b1;
			end
			OP_START: begin
				dist_we = 1'b1;
				dist_wd = '0;
				q_we    = 1'b1;
				q_addr  = '0;
				q_wd    = {YW'(cell_y_q), XW'(cell_x_q)};
			end
			OP_POP: begin
				q_re = 1'b1;
			end
			OP_CUR: begin
				dist_re   = 1'b1;
				dist_addr = cur_idx;
			end
			OP_NB_RD: begin
				pass_re   = 1'b1;
				pass_addr = nb_idx;
				dist_re   = 1'b1;
				dist_addr = nb_idx;
			end
			OP_NB_WR: begin
				dist_we   = relax;
				dist_addr = nb_idx_q;
				dist_wd   = nd[DIST_W-1:0];
				q_we      = relax && !q_full;
				q_addr    = tail_q[IDX_W-1:0];
			end
			default: begin
				pass_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pass_we) begin
			pass_mem[pass_addr] <= passable_q;
		end
		if (pass_re) begin
			pass_rd_q <= pass_mem[pass_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_addr] <= dist_wd;
		end
		if (dist_re) begin
			dist_rd_q <= dist_mem[dist_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_mem[q_addr] <= q_wd;
		end
		if (q_re) begin
			q_rd_q <= queue_mem[q_addr];
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			command_q  <= command;
			cell_x_q   <= cell_x;
			cell_y_q   <= cell_y;
			passable_q <= passable;
		end
		if (ctl.op == OP_CUR) begin
			cur_x_q <= q_rd_q[XW-1:0];
			cur_y_q <= q_rd_q[QW-1:XW];
		end
		if (ctl.cap_cur) begin
			cur_d_q <= dist_rd_q;
		end
		if (ctl.op == OP_NB_RD) begin
			nb_idx_q  <= nb_idx;
			nb_ok_q   <= nb_ok;
			nb_cell_q <= {ny[YW-1:0], nx[XW-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			clr_cnt_q    <= '0;
			move_power_q <= '0;
		end else begin
			if (cfg_we) begin
				move_power_q <= cfg_wdata;
			end
			if (ctl.op == OP_CLEAR) begin
				clr_cnt_q <= clr_last ? '0 : clr_cnt_q + IDX_W'(1);
			end
			if (ctl.op == OP_START) begin
				head_q <= '0;
				tail_q <= PTR_W'(1);
			end
			if (ctl.op == OP_POP) begin
				head_q <= head_q + PTR_W'(1);
			end
			if (q_we && ctl.op == OP_NB_WR) begin
				tail_q <= tail_q + PTR_W'(1);
			end
		end
	end

	always_comb begin
		case (ctl.res_src)
			RS_MEM:  res_d = in_ok ? dist_rd_q : UNREACHED;
			RS_ZERO: res_d = in_ok ? '0 : UNREACHED;
			RS_CUR:  res_d = cur_d_q;
			default: res_d = UNREACHED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			distance_q    <= res_d;
			in_range_q    <= (res_d != UNREACHED) && (res_d <= {1'b0, move_power_q});
			queue_empty_q <= (head_q >= tail_q);
		end
	end

	assign res_valid    = res_valid_q;
	assign distance_out = distance_q;
	assign in_range     = in_range_q;
	assign queue_empty  = queue_empty_q;

	assign stat.command  = command_q;
	assign stat.in_ok    = in_ok;
	assign stat.q_empty  = (head_q >= tail_q);
	assign stat.clr_last = clr_last;
	assign stat.res_free = !res_valid_q || res_ready;

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for grid_bfs_distance_field: drives load, start, expand and query
// words with random idling on both channels and compares every result word with a grid model.
// Depends on gbdf_pkg and the block's RTL; needs no other files.
`timescale 1ns / 1ps

module testbench;
	import gbdf_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int CYCLE_LIMIT = 800000;
	localparam int COLS        = GRID_WIDTH_DEF;
	localparam int ROWS        = GRID_HEIGHT_DEF;
	localparam int CELLS       = COLS * ROWS;
	localparam int POWER_MAX   = (1 << POWER_W) - 1;
	localparam int COORD_MAX   = (1 << COORD_IN_W) - 1;

	class distance_field_scoreboard;
		typedef struct packed {
			logic [DIST_W-1:0] distance;
			logic              in_range;
			logic              queue_empty;
		} field_word_t;

		bit          open_cell[CELLS];
		int unsigned reach_dist[CELLS];
		int          frontier[CELLS];
		int          front_head;
		int          front_tail;
		int unsigned move_power;
		field_word_t awaited_words[$];
		int          fail_count;

		function new();
			foreach (reach_dist[i]) reach_dist[i] = UNREACHED;
			front_head = 0;
			front_tail = 0;
			move_power = 0;
			fail_count = 0;
		endfunction

		function void push_cell(int cell_id);
			if (front_tail < CELLS) begin
				frontier[front_tail] = cell_id;
				front_tail++;
			end
		endfunction

		function void relax(int x, int y, int unsigned nd);
			int cell_id;
			if (x < 0 || y < 0 || x >= COLS || y >= ROWS)
				return;
			cell_id = y * COLS + x;
			if (open_cell[cell_id] && nd < UNREACHED && nd < reach_dist[cell_id]) begin
				reach_dist[cell_id] = nd;
				push_cell(cell_id);
			end
		endfunction

		function void note_command(logic [CMD_W-1:0] cmd, int x, int y, bit pb);
			bit          on_grid;
			int          cell_id;
			int          cur;
			int unsigned d;
			field_word_t w;
			on_grid = x < COLS && y < ROWS;
			cell_id = on_grid ? y * COLS + x : 0;
			d = UNREACHED;
			case (cmd)
				CMD_LOAD: begin
					if (on_grid) begin
						open_cell[cell_id] = pb;
						d = reach_dist[cell_id];
					end
				end
				CMD_START: begin
					if (on_grid) begin
						foreach (reach_dist[i]) reach_dist[i] = UNREACHED;
						reach_dist[cell_id] = 0;
						front_head = 0;
						front_tail = 0;
						push_cell(cell_id);
						d = 0;
					end
				end
				CMD_EXPAND: begin
					if (front_head < front_tail) begin
						cur = frontier[front_head];
						front_head++;
						d = reach_dist[cur];
						relax(cur % COLS + 1, cur / COLS, d + 1);
						relax(cur % COLS - 1, cur / COLS, d + 1);
						relax(cur % COLS, cur / COLS + 1, d + 1);
						relax(cur % COLS, cur / COLS - 1, d + 1);
					end
				end
				default: begin
					if (on_grid)
						d = reach_dist[cell_id];
				end
			endcase
			w.distance    = d[DIST_W-1:0];
			w.in_range    = d != UNREACHED && d <= move_power;
			w.queue_empty = front_head >= front_tail;
			awaited_words.insert(awaited_words.size(), w);
		endfunction

		task report(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			fail_count++;
		endtask

		task check_result(logic [DIST_W-1:0] d, logic r, logic qe);
			field_word_t w;
			if (awaited_words.size() == 0) begin
				report($sformatf("word distance %0d in_range %b queue_empty %b with none expected",
					d, r, qe));
			end else begin
				w = awaited_words[0];
				awaited_words.delete(0);
				if (d !== w.distance)
					report($sformatf("distance_out %0d, expected %0d", d, w.distance));
				if (r !== w.in_range)
					report($sformatf("in_range %b, expected %b", r, w.in_range));
				if (qe !== w.queue_empty)
					report($sformatf("queue_empty %b, expected %b", qe, w.queue_empty));
			end
		endtask

		function int head_cell();
			if (front_head < front_tail)
				return frontier[front_head];
			return -1;
		endfunction

		function int pending();
			return awaited_words.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cmd_valid;
	logic                  cmd_ready;
	logic [CMD_W-1:0]      command;
	logic [COORD_IN_W-1:0] cell_x;
	logic [COORD_IN_W-1:0] cell_y;
	logic                  passable;
	logic                  res_valid;
	logic                  res_ready;
	logic [DIST_W-1:0]     distance_out;
	logic                  in_range;
	logic                  queue_empty;
	logic                  cfg_we;
	logic [POWER_W-1:0]    cfg_wdata;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_off_left = 0;
	int cycle_count = 0;
	bit cell_loaded[CELLS];
	int loaded_cells[$];
	distance_field_scoreboard field_model = new();

	grid_bfs_distance_field DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.command      (command),
		.cell_x       (cell_x),
		.cell_y       (cell_y),
		.passable     (passable),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.distance_out (distance_out),
		.in_range     (in_range),
		.queue_empty  (queue_empty),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_left > 0) begin
				hold_off_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= $urandom_range(0, 99) >= stall_pct;
			end
		end
	end

	always @(posedge clk) begin
		if (res_valid && res_ready)
			field_model.check_result(distance_out, in_range, queue_empty);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("grid_bfs_distance_field regression: fail");
		$finish;
	end

	task automatic send_word(logic [CMD_W-1:0] cmd, int x, int y, bit pb);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		command   <= cmd;
		cell_x    <= COORD_IN_W'(x);
		cell_y    <= COORD_IN_W'(y);
		passable  <= pb;
		do
			@(posedge clk);
		while (!cmd_ready);
		field_model.note_command(cmd, x, y, pb);
		if (cmd == CMD_LOAD && !cell_loaded[y * COLS + x]) begin
			cell_loaded[y * COLS + x] = 1'b1;
			loaded_cells.insert(loaded_cells.size(), y * COLS + x);
		end
		@(negedge clk);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(negedge clk);
		while (field_model.pending() != 0)
			@(negedge clk);
	endtask

	task automatic set_move_power(int value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= POWER_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		field_model.move_power = value;
	endtask

	// An expansion reads the passability of every in-grid neighbour of the cell it pops,
	// so those cells are loaded first. Returns -2 for an empty queue, -1 when safe.
	function automatic int unloaded_neighbour();
		int head;
		int cx;
		int cy;
		head = field_model.head_cell();
		if (head < 0)
			return -2;
		cx = head % COLS;
		cy = head / COLS;
		if (cx + 1 < COLS && !cell_loaded[head + 1])
			return head + 1;
		if (cx > 0 && !cell_loaded[head - 1])
			return head - 1;
		if (cy + 1 < ROWS && !cell_loaded[head + COLS])
			return head + COLS;
		if (cy > 0 && !cell_loaded[head - COLS])
			return head - COLS;
		return -1;
	endfunction

	task automatic send_random_word();
		int  pick;
		int  cell_id;
		int  need;
		bit  want_query;
		pick = $urandom_range(0, 99);
		want_query = 1'b0;
		if (pick < 4 && loaded_cells.size() > 0) begin
			cell_id = loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
			send_word(CMD_START, cell_id % COLS, cell_id / COLS, $urandom_range(0, 1));
		end else if (pick < 18) begin
			cell_id = $urandom_range(0, CELLS - 1);
			send_word(CMD_LOAD, cell_id % COLS, cell_id / COLS, $urandom_range(0, 3) != 0);
		end else if (pick < 75) begin
			need = unloaded_neighbour();
			if (need >= 0)
				send_word(CMD_LOAD, need % COLS, need / COLS, $urandom_range(0, 4) != 0);
			else if (need == -1 || $urandom_range(0, 3) == 0)
				send_word(CMD_EXPAND, $urandom_range(0, COORD_MAX),
					$urandom_range(0, COORD_MAX), $urandom_range(0, 1));
			else
				want_query = 1'b1;
		end else begin
			want_query = 1'b1;
		end
		if (want_query) begin
			if (loaded_cells.size() > 0 && $urandom_range(0, 1))
				cell_id = loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
			else
				cell_id = $urandom_range(0, CELLS - 1);
			send_word(CMD_QUERY, cell_id % COLS, cell_id / COLS, $urandom_range(0, 1));
		end
	endtask

	task automatic run_phase(int sender_pct, int receiver_pct, int words);
		for (int i = 0; i < words; i++) begin
			if (i % 32 == 0) begin
				if ($urandom_range(0, 3) == 0) begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end else begin
					send_idle_pct = sender_pct;
					stall_pct     = receiver_pct;
				end
			end
			send_random_word();
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		command   = CMD_LOAD;
		cell_x    = '0;
		cell_y    = '0;
		passable  = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		send_word(CMD_EXPAND, 0, 0, 0);
		set_move_power(3);
		send_word(CMD_QUERY, 0, 0, 0);
		send_word(CMD_LOAD, 0, 0, 1);
		send_word(CMD_LOAD, 1, 0, 1);
		send_word(CMD_LOAD, 0, 1, 0);
		send_word(CMD_START, 0, 0, 0);
		send_word(CMD_QUERY, 0, 0, 0);
		send_word(CMD_EXPAND, 0, 0, 0);
		send_word(CMD_QUERY, 1, 0, 0);
		send_word(CMD_QUERY, 0, 1, 0);
		send_word(CMD_LOAD, 2, 0, 1);
		send_word(CMD_LOAD, 1, 1, 1);
		send_word(CMD_EXPAND, COORD_MAX, COORD_MAX, 1);
		send_word(CMD_LOAD, COORD_MAX, COORD_MAX, 0);
		send_word(CMD_START, COORD_MAX, COORD_MAX, 1);
		send_word(CMD_QUERY, 2, 0, 0);
		send_word(CMD_LOAD, COORD_MAX - 1, COORD_MAX, 1);
		send_word(CMD_LOAD, COORD_MAX, COORD_MAX - 1, 1);
		send_word(CMD_EXPAND, 0, 0, 0);
		send_word(CMD_QUERY, COORD_MAX, COORD_MAX - 1, 0);
		send_word(CMD_LOAD, COORD_MAX, COORD_MAX - 1, 0);
		send_word(CMD_QUERY, COORD_MAX, 0, 1);
		send_word(CMD_QUERY, 0, COORD_MAX, 0);

		set_move_power(POWER_MAX);
		run_phase(0, 0, 150);
		hold_off_left = 300;
		run_phase(0, 0, 140);

		set_move_power(0);
		run_phase(63, 0, 150);
		wait_drained();
		run_phase(63, 0, 140);

		set_move_power($urandom_range(0, 40));
		run_phase(0, 63, 290);

		set_move_power($urandom_range(0, POWER_MAX));
		run_phase(34, 34, 150);
		hold_off_left = 300;
		run_phase(34, 34, 140);

		stall_pct = 0;
		wait_drained();
		repeat (16) @(negedge clk);
		if (field_model.fail_count == 0 && field_model.pending() == 0)
			$display("grid_bfs_distance_field regression: pass");
		else
			$display("grid_bfs_distance_field regression: fail");
		$finish;
	end

endmodule

>>> sim.f
src/gbdf_pkg.sv
src/gbdf_ctrl.sv
src/gbdf_dpath.sv
src/grid_bfs_distance_field.sv
dv/testbench.sv
